/* hw/rtl/md_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the modular division pipeline (prime 1000000007).
// No dependencies; used by every module under hw/rtl.
package md_pkg;

  localparam int MD_W        = 30;
  localparam int MD_IN_W     = 63;
  localparam int MD_EXP_BITS = 30;
  localparam int MD_PROD_W   = 60;
  localparam int MD_RED_W    = 61;

  localparam logic [MD_W-1:0] MD_PRIME = 30'd1000000007;
  localparam logic [MD_W-1:0] MD_EXP   = 30'd1000000005;

  // 2^30 mod P, folds the upper part of a wide operand
  localparam logic [26:0] MD_FOLD_C = 27'd73741817;

  localparam logic [63:0] MD_BARRETT_W = (64'd1 << 62) / {34'd0, MD_PRIME};
  localparam logic [32:0] MD_BARRETT_M = MD_BARRETT_W[32:0];

  localparam logic [31:0] MD_P32  = {2'b00, MD_PRIME};
  localparam logic [31:0] MD_2P32 = {1'b0, MD_PRIME, 1'b0};

  localparam int MD_RED_LAT  = 4;
  localparam int MD_MUL_LAT  = MD_RED_LAT + 1;
  localparam int MD_PREP_LAT = MD_RED_LAT + 2;
  localparam int MD_SLOTS    = 2 * (MD_EXP_BITS - 1);

  typedef logic [MD_W-1:0] md_res_t;

  typedef struct packed {
    logic    valid;
    md_res_t base;
    md_res_t num;
  } md_side_t;

endpackage

/* hw/rtl/md_reduce.sv */
`timescale 1ns / 1ps
// Four-stage Barrett reduction of a 61-bit value modulo the prime.
// Depends on md_pkg.
module md_reduce import md_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [MD_RED_W-1:0] x_i,
  output md_res_t             r_o
);

  logic [64:0] am;
  logic [61:0] qp;
  logic [31:0] qe_nxt, qe_r;
  logic [31:0] xl1_r, xl2_r;
  logic [31:0] pr_nxt, pr_r;
  logic [31:0] r_nxt, r_r;
  md_res_t     res_nxt, res_r;

  always_comb begin
    am      = 65'(x_i[60:29]) * 65'(MD_BARRETT_M);
    qe_nxt  = am[64:33];
    qp      = 62'(qe_r) * 62'(MD_PRIME);
    pr_nxt  = qp[31:0];
    r_nxt   = xl2_r - pr_r;
    if (r_r >= MD_2P32) begin
      res_nxt = md_res_t'(r_r - MD_2P32);
    end else if (r_r >= MD_P32) begin
      res_nxt = md_res_t'(r_r - MD_P32);
    end else begin
      res_nxt = r_r[MD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qe_r  <= qe_nxt;
      xl1_r <= x_i[31:0];
      pr_r  <= pr_nxt;
      xl2_r <= xl1_r;
      r_r   <= r_nxt;
      res_r <= res_nxt;
    end
  end

  assign r_o = res_r;

endmodule

/* hw/rtl/md_mulmod.sv */
`timescale 1ns / 1ps
// Five-stage modular multiplier: registered 30x30 product, then Barrett reduction.
// Depends on md_pkg and md_reduce.
module md_mulmod import md_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  md_res_t a_i,
  input  md_res_t b_i,
  output md_res_t p_o
);

  logic [MD_PROD_W-1:0] prod_nxt, prod_r;

  assign prod_nxt = MD_PROD_W'(a_i) * MD_PROD_W'(b_i);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  md_reduce u_reduce (
    .clk (clk),
    .en  (en),
    .x_i ({1'b0, prod_r}),
    .r_o (p_o)
  );

endmodule

/* hw/rtl/md_sideline.sv */
`timescale 1ns / 1ps
// Delay line that carries valid, base and dividend alongside one modular multiplier.
// Depends on md_pkg.
module md_sideline import md_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  md_side_t side_i,
  output md_side_t side_o
);

  logic [MD_MUL_LAT-1:0] vld_r;
  md_res_t               base_r [MD_MUL_LAT];
  md_res_t               num_r  [MD_MUL_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[MD_MUL_LAT-2:0], side_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r[0] <= side_i.base;
      num_r[0]  <= side_i.num;
      for (int i = 1; i < MD_MUL_LAT; i++) begin
        base_r[i] <= base_r[i-1];
        num_r[i]  <= num_r[i-1];
      end
    end
  end

  assign side_o.valid = vld_r[MD_MUL_LAT-1];
  assign side_o.base  = base_r[MD_MUL_LAT-1];
  assign side_o.num   = num_r[MD_MUL_LAT-1];

endmodule

/* hw/rtl/md_prep.sv */
`timescale 1ns / 1ps
// Input stage: folds each 63-bit operand to 61 bits, then reduces it modulo the prime.
// Depends on md_pkg and md_reduce.
module md_prep import md_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [MD_IN_W-1:0] dividend,
  input  logic [MD_IN_W-1:0] divisor,
  output md_side_t           side_o
);

  logic [MD_IN_W-1:0]    op_in  [2];
  md_res_t               op_red [2];
  logic [MD_PREP_LAT-1:0] vld_r;

  assign op_in[0] = dividend;
  assign op_in[1] = divisor;

  for (genvar g = 0; g < 2; g++) begin : g_op
    logic [MD_PROD_W-1:0] fp_nxt, fp_r;
    md_res_t              lo_r;
    logic [MD_RED_W-1:0]  sum_nxt, sum_r;

    assign fp_nxt  = MD_PROD_W'(op_in[g][62:30]) * MD_PROD_W'(MD_FOLD_C);
    assign sum_nxt = MD_RED_W'(fp_r) + MD_RED_W'(lo_r);

    always_ff @(posedge clk) begin
      if (en) begin
        fp_r  <= fp_nxt;
        lo_r  <= op_in[g][MD_W-1:0];
        sum_r <= sum_nxt;
      end
    end

    md_reduce u_reduce (
      .clk (clk),
      .en  (en),
      .x_i (sum_r),
      .r_o (op_red[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[MD_PREP_LAT-2:0], in_valid};
    end
  end

  assign side_o.valid = vld_r[MD_PREP_LAT-1];
  assign side_o.num   = op_red[0];
  assign side_o.base  = op_red[1];

  a_num_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    side_o.valid |-> side_o.num < MD_PRIME)
    else $error("reduced dividend out of range");

  a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    side_o.valid |-> side_o.base < MD_PRIME)
    else $error("reduced divisor out of range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !side_o.valid)
    else $error("valid survives reset");

endmodule

/* hw/rtl/modular_division_fermat_unit.sv */
`timescale 1ns / 1ps
// Modular division modulo 1000000007: dividend * divisor^(P-2) mod P.
// Operand reduction first, then 44 modular multipliers
// (29 squarings, 14 multiplies by the divisor, one by the dividend), fully unrolled.
// Throughput one transfer per cycle; a stalled output freezes the whole pipeline.
// Reset (rst_n low, synchronous) clears every valid bit; data registers are not reset.
module modular_division_fermat_unit import md_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [62:0] dividend, [125:63] divisor, [127:126] zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // [29:0] quotient, [31:30] zero
);

  logic     en;
  md_res_t  acc  [MD_SLOTS+1];
  md_side_t side [MD_SLOTS+1];
  md_side_t prep_side;
  md_side_t fin_side;
  md_res_t  quotient;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  md_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .dividend (in_tdata[62:0]),
    .divisor  (in_tdata[125:63]),
    .side_o   (prep_side)
  );

  // leading exponent bit is one: start from the base itself
  assign acc[0]  = prep_side.base;
  assign side[0] = prep_side;

  for (genvar k = 0; k < MD_EXP_BITS - 1; k++) begin : g_bit
    localparam int BIT = MD_EXP_BITS - 2 - k;

    md_mulmod u_sqr (
      .clk (clk),
      .en  (en),
      .a_i (acc[2*k]),
      .b_i (acc[2*k]),
      .p_o (acc[2*k+1])
    );

    md_sideline u_sqr_side (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .side_i (side[2*k]),
      .side_o (side[2*k+1])
    );

    if (MD_EXP[BIT]) begin : g_mul
      md_mulmod u_mul (
        .clk (clk),
        .en  (en),
        .a_i (acc[2*k+1]),
        .b_i (side[2*k+1].base),
        .p_o (acc[2*k+2])
      );

      md_sideline u_mul_side (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .side_i (side[2*k+1]),
        .side_o (side[2*k+2])
      );
    end else begin : g_skip
      assign acc[2*k+2]  = acc[2*k+1];
      assign side[2*k+2] = side[2*k+1];
    end
  end

  md_mulmod u_final (
    .clk (clk),
    .en  (en),
    .a_i (acc[MD_SLOTS]),
    .b_i (side[MD_SLOTS].num),
    .p_o (quotient)
  );

  md_sideline u_final_side (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (side[MD_SLOTS]),
    .side_o (fin_side)
  );

  assign out_tvalid = fin_side.valid;
  assign out_tdata  = {2'b00, quotient};

  a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[MD_W-1:0] < MD_PRIME)
    else $error("quotient not fully reduced");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid survives reset");

endmodule

/* bench/modular_division_fermat_checker.sv */
`timescale 1ns / 1ps
// Watches both stream channels of the modular division unit and predicts each quotient.
// Depends on md_pkg for widths and the prime; reports a running failure count to the bench.
module modular_division_fermat_checker import md_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,   // [62:0] dividend, [125:63] divisor, [127:126] zero
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,  // [29:0] quotient, [31:30] zero
  output int           fail_count,
  output int           pending
);

  localparam logic [63:0] PRIME_WIDE = 64'(MD_PRIME);

  md_res_t pending_quotients[$];
  int      mismatches = 0;

  function automatic md_res_t fermat_quotient(logic [MD_IN_W-1:0] dividend,
                                              logic [MD_IN_W-1:0] divisor);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] acc;
    int          b;
    num = 64'(dividend) % PRIME_WIDE;
    den = 64'(divisor) % PRIME_WIDE;
    acc = 64'd1;
    for (b = MD_EXP_BITS - 1; b >= 0; b--) begin
      acc = (acc * acc) % PRIME_WIDE;
      if (MD_EXP[b]) begin
        acc = (acc * den) % PRIME_WIDE;
      end
    end
    return md_res_t'((num * acc) % PRIME_WIDE);
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    md_res_t want;
    md_res_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_quotients.push_back(fermat_quotient(in_tdata[MD_IN_W-1:0],
                                                    in_tdata[2*MD_IN_W-1:MD_IN_W]));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[MD_W-1:0];
        if (pending_quotients.size() == 0) begin
          $error("quotient transfer with no prediction pending, actual %0d", got);
          mismatches++;
        end else begin
          want = pending_quotients.pop_front();
          if (got !== want) begin
            $error("quotient mismatch: expected %0d, actual %0d", want, got);
            mismatches++;
          end
        end
      end
      fail_count <= mismatches;
      pending    <= pending_quotients.size();
    end
  end

endmodule

/* bench/modular_division_fermat_unit_test.sv */
`timescale 1ns / 1ps
// Top of the modular division bench: clock, reset, operand stream and output back-pressure.
// Depends on md_pkg, modular_division_fermat_unit and modular_division_fermat_checker.
module modular_division_fermat_unit_test import md_pkg::*;;

  localparam int          ITEM_COUNT  = 400;
  localparam int          IDLE_PCT    = 29;
  localparam int          DRAIN_WAIT  = 240;
  localparam logic [63:0] PRIME_WIDE  = 64'(MD_PRIME);
  localparam logic [62:0] OPERAND_MAX = {63{1'b1}};

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // [62:0] dividend, [125:63] divisor, [127:126] zero
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;  // [29:0] quotient, [31:30] zero
  int           fail_count;
  int           pending;
  int           send_idle_pct;

  modular_division_fermat_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  modular_division_fermat_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [62:0] random_operand();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[62:0];
  endfunction

  function automatic logic [62:0] prime_multiple();
    logic [63:0] k;
    k = 64'($urandom);
    return 63'(k * PRIME_WIDE);
  endfunction

  function automatic logic [62:0] near_prime_multiple();
    logic [63:0] k;
    logic [63:0] v;
    k = 64'($urandom_range(0, 1000));
    v = k * PRIME_WIDE + 64'($urandom_range(0, 8)) - 64'd4;
    return v[62:0];
  endfunction

  function automatic logic [62:0] shaped_operand(int sel);
    case (sel)
      0:       return prime_multiple();
      1:       return 63'($urandom_range(0, 1000000017));
      2:       return near_prime_multiple();
      default: return random_operand();
    endcase
  endfunction

  task automatic send_division(input logic [62:0] dividend, input logic [62:0] divisor);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, divisor, dividend};
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int cycle;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (cycle = 0; ; cycle++) begin
      if (cycle >= 300 && cycle < 900) begin
        out_tready <= 1'b0;
      end else if (cycle >= 1000 && cycle < 1400) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  initial begin
    int          i;
    int          sel_num;
    int          sel_den;
    logic [62:0] num;
    logic [62:0] den;
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    send_idle_pct  = IDLE_PCT;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_division(63'd0, 63'd0);
    send_division(63'd0, 63'd1);
    send_division(63'd1, 63'd1);
    send_division(63'd1, 63'd2);
    send_division(63'd12345, 63'd2);
    send_division(OPERAND_MAX, OPERAND_MAX);
    send_division(OPERAND_MAX, 63'd1);
    send_division(63'd1, OPERAND_MAX);
    send_division(63'(PRIME_WIDE), 63'd5);
    send_division(63'd5, 63'(PRIME_WIDE));
    send_division(OPERAND_MAX, 63'(PRIME_WIDE));
    send_division(63'(PRIME_WIDE - 1), 63'(PRIME_WIDE - 1));
    send_division(63'(PRIME_WIDE + 1), 63'(PRIME_WIDE - 1));
    send_division(63'(2 * PRIME_WIDE - 1), 63'(PRIME_WIDE + 1));
    send_division(63'(PRIME_WIDE << 32), 63'd7);
    send_division(63'd7, 63'(PRIME_WIDE << 32));
    send_division(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    send_division(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
    send_division(63'h4000_0000_0000_0000, 63'h4000_0000_0000_0000);
    send_division(63'd1000000006, 63'd3);

    for (i = 0; i < ITEM_COUNT; i++) begin
      send_idle_pct = (i >= 150 && i < 250) ? 0 : IDLE_PCT;
      sel_num = $urandom_range(0, 9);
      sel_den = $urandom_range(0, 9);
      num = shaped_operand(sel_num < 5 ? 3 : sel_num - 5);
      den = shaped_operand(sel_den < 5 ? 3 : sel_den - 5);
      send_division(num, den);
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
